// ===== rtl/julia_inverse_iteration_plotter_top_assert.svh =====
// assertion macros for the julia inverse iteration plotter
`ifndef JULIA_INVERSE_ITERATION_PLOTTER_TOP_ASSERT_SVH
`define JULIA_INVERSE_ITERATION_PLOTTER_TOP_ASSERT_SVH

// same-cycle implication
`define JIIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JIIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/jiip_pkg.sv =====
// constants, codes and helpers for the julia inverse iteration plotter
package jiip_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int SCREEN_WIDTH = 640;
    localparam int SCREEN_LINES = 200;
    localparam int Y_MARGIN     = 10;

    localparam int PW  = 24;
    localparam int WW  = PW + 1;
    localparam int OFW = 14;
    localparam int MKW = 16;

    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 80;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_C_REAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG = 2'd1;

    localparam logic REQ_STEP = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic signed [PW-1:0] C_REAL_RST = PW'(((longint'(2) << FRAC_BITS) + 5) / 10);
    localparam logic signed [PW-1:0] C_IMAG_RST = PW'(((longint'(3) << FRAC_BITS) + 5) / 10);

    // square root unit sizing
    localparam int RAD_MIN = 26 + FRAC_BITS;
    localparam int RAD_RAW = (RAD_MIN > 2 * WW) ? RAD_MIN : 2 * WW;
    localparam int RADW    = ((RAD_RAW + 1) / 2) * 2;
    localparam int ROOTW   = RADW / 2;
    localparam int SUMW    = ROOTW + 2;
    localparam int CNTW    = $clog2(ROOTW);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(ROOTW - 1);

    // pixel mapping
    localparam int MAPW  = 48;
    localparam int PX_SH = FRAC_BITS + 3;
    localparam int PY_SH = FRAC_BITS + 2;
    localparam logic signed [MAPW-1:0] PX_K    = MAPW'(SCREEN_WIDTH);
    localparam logic signed [MAPW-1:0] PY_K    = MAPW'(SCREEN_LINES - Y_MARGIN);
    localparam logic signed [MAPW-1:0] PX_BIAS =
        MAPW'(longint'(4 * SCREEN_WIDTH - 40) <<< FRAC_BITS);
    localparam logic signed [MAPW-1:0] PY_BIAS =
        MAPW'(longint'(2 * (SCREEN_LINES - Y_MARGIN)) <<< FRAC_BITS);
    localparam logic signed [MAPW-1:0] PX_RND  = MAPW'((longint'(1) << PX_SH) - 1);
    localparam logic signed [MAPW-1:0] PY_RND  = MAPW'((longint'(1) << PY_SH) - 1);
    localparam logic signed [MAPW-1:0] PX_LIM  = MAPW'(SCREEN_WIDTH);
    localparam logic signed [MAPW-1:0] PY_LIM  = MAPW'(SCREEN_LINES);
    localparam logic signed [MAPW-1:0] ROW_WORDS = MAPW'(SCREEN_WIDTH / 8);

    localparam logic [MKW-1:0] MASK_TOP = 16'h8000;

    // saturate a signed root to the point width
    function automatic logic signed [PW-1:0] sat_pw(input logic signed [ROOTW:0] v);
        logic signed [ROOTW:0] hi;
        logic signed [ROOTW:0] lo;
        hi = (ROOTW+1)'((longint'(1) << (PW - 1)) - 1);
        lo = -hi - (ROOTW+1)'(1);
        if (v > hi) begin
            sat_pw = hi[PW-1:0];
        end else if (v < lo) begin
            sat_pw = lo[PW-1:0];
        end else begin
            sat_pw = v[PW-1:0];
        end
    endfunction

endpackage

// ===== rtl/julia_inverse_iteration_plotter_top.sv =====
// julia inverse iteration plotter: fixed-point complex root step and pixel mapping
// step item: squares of the real and imaginary parts in turn on one multiplier,
//   then three square roots (modulus, real, imaginary) on one shared root unit
// load item: goes straight to pixel mapping and output; one item in flight, next transfer
//   accepted once the result is registered, held off by output stalls
// reset (synchronous, active low): point cleared to zero, c set to 0.2 + 0.3i, no result pending
`include "julia_inverse_iteration_plotter_top_assert.svh"

module julia_inverse_iteration_plotter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // branch, load_real, load_imag
    input  logic [jiip_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // req_type
    input  logic [jiip_pkg::S_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // point_real, point_imag, in_bounds, word_offset, pixel_mask
    output logic [jiip_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jiip_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [jiip_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import jiip_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_SQY  = 4'd2;
    localparam logic [3:0] ST_ROOT = 4'd3;
    localparam logic [3:0] ST_LOAD = 4'd4;
    localparam logic [3:0] ST_FIX  = 4'd5;
    localparam logic [3:0] ST_MAP  = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;

    logic [3:0]              r_state, n_state;
    logic [1:0]              r_phase;
    logic [CNTW-1:0]         r_cnt;
    logic signed [PW-1:0]    r_c_real, r_c_imag;
    logic signed [PW-1:0]    r_cur_real, r_cur_imag;
    logic signed [WW-1:0]    r_wx, r_wy;
    logic                    r_branch;
    logic [RADW-1:0]         r_rad;
    logic [ROOTW+1:0]        r_rem, n_rem;
    logic [ROOTW-1:0]        r_root, n_root;
    logic [ROOTW-1:0]        r_mod, r_re;
    logic signed [MAPW-1:0]  r_px, r_py;
    logic                    r_ovalid;
    logic signed [PW-1:0]    r_o_real, r_o_imag;
    logic                    r_o_inb;
    logic [OFW-1:0]          r_o_off;
    logic [MKW-1:0]          r_o_mask;

    logic                    in_xfer, out_free;
    logic signed [WW-1:0]    ld_wx, ld_wy;
    logic [WW-1:0]           ax, ay, mul_op;
    logic [2*WW-1:0]         prod;
    logic [ROOTW+3:0]        rem_sh, trial, diff;
    logic                    ge;
    logic [ROOTW-1:0]        base;
    logic signed [SUMW-1:0]  wxe, sum;
    logic signed [ROOTW:0]   re_s, im_s;
    logic                    neg_re, neg_im;
    logic signed [MAPW-1:0]  sx, sy, px_num, py_num;
    logic                    inb;
    logic [MAPW-1:0]         off_full;

    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_ovalid || i_m_axis_tready;

    assign ld_wx = WW'(r_cur_real) - WW'(r_c_real);
    assign ld_wy = WW'(r_cur_imag) - WW'(r_c_imag);

    // shared squaring multiplier
    assign ax     = r_wx[WW-1] ? WW'(-r_wx) : WW'(r_wx);
    assign ay     = r_wy[WW-1] ? WW'(-r_wy) : WW'(r_wy);
    assign mul_op = (r_state == ST_SQX) ? ax : ay;
    assign prod   = (2*WW)'(mul_op) * (2*WW)'(mul_op);

    // one digit of the shared square root
    assign rem_sh = {r_rem, r_rad[RADW-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;
    assign n_rem  = ge ? diff[ROOTW+1:0] : rem_sh[ROOTW+1:0];
    assign n_root = {r_root[ROOTW-2:0], ge};

    // radicand for the real and imaginary roots
    assign base = (r_phase == 2'd0) ? r_root : r_mod;
    assign wxe  = SUMW'(r_wx);
    assign sum  = $signed({2'b00, base}) + ((r_phase == 2'd0) ? wxe : -wxe);

    assign neg_re = !r_branch;
    assign neg_im = r_wy[WW-1] ^ !r_branch;
    assign re_s   = neg_re ? -$signed({1'b0, r_re})   : $signed({1'b0, r_re});
    assign im_s   = neg_im ? -$signed({1'b0, r_root}) : $signed({1'b0, r_root});

    // pixel mapping
    assign sx     = MAPW'(r_cur_real);
    assign sy     = MAPW'(r_cur_imag);
    assign px_num = sx * PX_K + PX_BIAS;
    assign py_num = PY_BIAS - sy * PY_K;
    assign inb    = (r_px >= 0) && (r_px < PX_LIM) && (r_py >= 0) && (r_py < PY_LIM);
    assign off_full = MAPW'((r_px >>> 4) <<< 1) + MAPW'(r_py * ROW_WORDS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_s_axis_tuser[0] == REQ_LOAD) ? ST_MAP : ST_SQX;
                end
            end
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = (r_phase == 2'd2) ? ST_FIX : ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_ROOT;
            ST_FIX:  n_state = ST_MAP;
            ST_MAP:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ovalid   <= 1'b0;
            r_c_real   <= C_REAL_RST;
            r_c_imag   <= C_IMAG_RST;
            r_cur_real <= '0;
            r_cur_imag <= '0;
            r_phase    <= 2'd0;
            r_cnt      <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_C_REAL: r_c_real <= i_cfg_data;
                    REG_C_IMAG: r_c_imag <= i_cfg_data;
                    default: ;
                endcase
            end

            if ((r_state == ST_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_branch <= i_s_axis_tdata[0];
                        r_wx     <= ld_wx;
                        r_wy     <= ld_wy;
                        if (i_s_axis_tuser[0] == REQ_LOAD) begin
                            r_cur_real <= i_s_axis_tdata[24:1];
                            r_cur_imag <= i_s_axis_tdata[48:25];
                        end
                    end
                end
                ST_SQX: begin
                    r_rad <= RADW'(prod);
                end
                ST_SQY: begin
                    r_rad   <= r_rad + RADW'(prod);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_phase <= 2'd0;
                end
                ST_ROOT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_rad  <= r_rad << 2;
                    r_cnt  <= r_cnt + 1'b1;
                end
                ST_LOAD: begin
                    if (r_phase == 2'd0) begin
                        r_mod <= r_root;
                    end else begin
                        r_re <= r_root;
                    end
                    r_rad   <= RADW'(sum[SUMW-2:0]) << (FRAC_BITS - 1);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_phase <= r_phase + 1'b1;
                end
                ST_FIX: begin
                    r_cur_real <= sat_pw(re_s);
                    r_cur_imag <= sat_pw(im_s);
                end
                ST_MAP: begin
                    r_px <= (px_num < 0) ? ((px_num + PX_RND) >>> PX_SH) : (px_num >>> PX_SH);
                    r_py <= (py_num < 0) ? ((py_num + PY_RND) >>> PY_SH) : (py_num >>> PY_SH);
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_o_real <= r_cur_real;
                        r_o_imag <= r_cur_imag;
                        r_o_inb  <= inb;
                        r_o_off  <= inb ? off_full[OFW-1:0] : '0;
                        r_o_mask <= inb ? (MASK_TOP >> r_px[3:0]) : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_o_mask, r_o_off, r_o_inb, r_o_imag, r_o_real};

    `JIIP_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !o_s_axis_tready, "input taken while busy")
    `JIIP_ASSERT_NEXT(a_load_maps, in_xfer && (i_s_axis_tuser[0] == REQ_LOAD), r_state == ST_MAP, "load item did not go to mapping")
    `JIIP_ASSERT_NOW(a_off_zero, r_ovalid && !r_o_inb, (r_o_off == '0) && (r_o_mask == '0), "off-screen result has pixel data")
    `JIIP_ASSERT_NOW(a_mask_onehot, r_ovalid && r_o_inb, $onehot(r_o_mask), "pixel mask not one-hot")

endmodule
